[sv/obj_face_index_dedup_top_defines.svh]
// assertion macros for the face index dedup block
`ifndef OBJ_FACE_INDEX_DEDUP_TOP_DEFINES_SVH
`define OBJ_FACE_INDEX_DEDUP_TOP_DEFINES_SVH
`ifndef SYNTH
`define OFD_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define OFD_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define OFD_ASSERT_IMP(label, clk, rst_n, a, c)
`define OFD_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

[sv/ofd_pkg.sv]
package ofd_pkg;
    localparam int TableDepth = 1024;
    localparam int IndexBits = 20;
    localparam logic [7:0] CharSlash = 8'h2f;
    localparam logic [7:0] CharSpace = 8'h20;
    localparam logic [7:0] CharZero = 8'h30;
    localparam logic [7:0] CharNine = 8'h39;
    localparam int QueueDepth = 2;
endpackage

[sv/obj_face_index_dedup_top.sv]
// Face corner deduplication: one character word per cycle on the input; each corner (ended by
// a space or the line's last character) yields one result word with the position, texture and
// normal indices and a unique vertex index (or table_full set and index zero when a new key
// finds the table full). Characters keep entering at one per cycle while the key register and
// the two-entry key queue have room. The table search reads and compares one stored key at a
// time (StRead, then StCmp), over N entries, where N is at least one and at most the fill count;
// the back end takes no new key until its result word is loaded into the output registers.
module obj_face_index_dedup_top #(
    parameter int TABLE_DEPTH = ofd_pkg::TableDepth,
    parameter int INDEX_BITS = ofd_pkg::IndexBits
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          text_char,
    input  logic                line_last,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [INDEX_BITS-1:0] vertex_index,
    output logic                is_new,
    output logic signed [INDEX_BITS:0] pos_index,
    output logic signed [INDEX_BITS:0] uv_index,
    output logic signed [INDEX_BITS:0] norm_index,
    output logic                table_full
);
    localparam int KeyBits = 3 * INDEX_BITS + 3;

    logic                kv, ks, qv, qs;
    logic [INDEX_BITS:0] kp, ku, kn;
    logic [KeyBits-1:0]  qd;

    ofd_front #(.INDEX_BITS(INDEX_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .text_char(text_char), .line_last(line_last),
        .in_valid(in_valid), .in_stall(in_stall), .key_valid(kv), .key_stall(ks),
        .key_pos(kp), .key_uv(ku), .key_norm(kn)
    );

    ofd_queue #(.WIDTH(KeyBits), .DEPTH(ofd_pkg::QueueDepth)) u_queue (
        .clk(clk), .rst_n(rst_n), .wr_valid(kv), .wr_stall(ks), .wr_data({kp, ku, kn}),
        .rd_valid(qv), .rd_stall(qs), .rd_data(qd)
    );

    ofd_back #(.TABLE_DEPTH(TABLE_DEPTH), .INDEX_BITS(INDEX_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .key_valid(qv), .key_stall(qs), .key_data(qd),
        .out_valid(out_valid), .out_stall(out_stall), .vertex_index(vertex_index),
        .is_new(is_new), .pos_index(pos_index), .uv_index(uv_index),
        .norm_index(norm_index), .table_full(table_full)
    );
endmodule

[sv/ofd_front.sv]
module ofd_front #(
    parameter int INDEX_BITS = ofd_pkg::IndexBits
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [7:0]            text_char,
    input  logic                  line_last,
    input  logic                  in_valid,
    output logic                  in_stall,
    output logic                  key_valid,
    input  logic                  key_stall,
    output logic [INDEX_BITS:0]   key_pos,
    output logic [INDEX_BITS:0]   key_uv,
    output logic [INDEX_BITS:0]   key_norm
);
    localparam logic [INDEX_BITS-1:0] IdxMax = {INDEX_BITS{1'b1}};
    localparam int AccBits = INDEX_BITS + 4;

    logic [INDEX_BITS-1:0] acc_reg;
    logic                  pend_reg;
    logic [1:0]            slash_reg;
    logic                  skip_reg;
    logic [INDEX_BITS:0]   pos_reg, uv_reg, norm_reg;
    logic                  kv_reg;
    logic [INDEX_BITS:0]   kp_reg, ku_reg, kn_reg;

    logic                  take;
    logic                  is_digit;
    logic [AccBits-1:0]    acc_wide;
    logic [INDEX_BITS-1:0] acc_sat;
    logic                  commit;
    logic [INDEX_BITS-1:0] cval;
    logic [INDEX_BITS:0]   cval_m1;
    logic [1:0]            slash_next;
    logic [INDEX_BITS:0]   pos_next, uv_next, norm_next;
    logic                  emit;

    assign in_stall = kv_reg && key_stall;
    assign take = in_valid && !in_stall;
    assign is_digit = text_char inside {[ofd_pkg::CharZero:ofd_pkg::CharNine]};
    assign acc_wide = {4'd0, acc_reg} * AccBits'(10)
        + AccBits'(text_char - ofd_pkg::CharZero);
    assign acc_sat = (acc_wide > AccBits'(IdxMax)) ? IdxMax : acc_wide[INDEX_BITS-1:0];
    assign commit = is_digit ? line_last : pend_reg;
    assign cval = is_digit ? acc_sat : acc_reg;
    assign cval_m1 = {1'b0, cval} - {{INDEX_BITS{1'b0}}, 1'b1};

    always_comb
    begin
        pos_next = pos_reg;
        uv_next = uv_reg;
        norm_next = norm_reg;
        if (commit)
        begin
            case (slash_reg)
                2'd0: pos_next = cval_m1;
                2'd1: uv_next = cval_m1;
                2'd2: norm_next = cval_m1;
                default: ;
            endcase
        end
        slash_next = slash_reg;
        if (!is_digit && text_char == ofd_pkg::CharSlash && slash_reg != 2'd3)
            slash_next = slash_reg + 2'd1;
    end

    assign emit = !(skip_reg && !is_digit) && (text_char == ofd_pkg::CharSpace || line_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            slash_reg <= 2'd0;
            skip_reg <= 1'b1;
            acc_reg <= '0;
            pos_reg <= '0;
            uv_reg <= '0;
            norm_reg <= '0;
            kv_reg <= 1'b0;
        end
        else
        begin
            if (take && emit)
                kv_reg <= 1'b1;
            else if (kv_reg && !key_stall)
                kv_reg <= 1'b0;
            if (take)
            begin
                if (line_last)
                begin
                    pend_reg <= 1'b0;
                    slash_reg <= 2'd0;
                    skip_reg <= 1'b1;
                    acc_reg <= '0;
                    pos_reg <= '0;
                    uv_reg <= '0;
                    norm_reg <= '0;
                end
                else if (!(skip_reg && !is_digit))
                begin
                    skip_reg <= 1'b0;
                    pos_reg <= pos_next;
                    uv_reg <= uv_next;
                    norm_reg <= norm_next;
                    slash_reg <= emit ? 2'd0 : slash_next;
                    if (is_digit)
                    begin
                        acc_reg <= acc_sat;
                        pend_reg <= 1'b1;
                    end
                    else if (commit)
                    begin
                        acc_reg <= '0;
                        pend_reg <= 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            kp_reg <= pos_next;
            ku_reg <= uv_next;
            kn_reg <= norm_next;
        end
    end

    assign key_valid = kv_reg;
    assign key_pos = kp_reg;
    assign key_uv = ku_reg;
    assign key_norm = kn_reg;
endmodule

[sv/ofd_queue.sv]
module ofd_queue #(
    parameter int WIDTH = 63,
    parameter int DEPTH = ofd_pkg::QueueDepth
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_stall,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_stall,
    output logic [WIDTH-1:0] rd_data
);
    localparam int PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0]   mem_reg [DEPTH];
    logic [PtrBits-1:0] wp_reg, rp_reg;
    logic [PtrBits:0]   cnt_reg;
    logic               wr, rd;

    assign wr_stall = (cnt_reg == (PtrBits+1)'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign wr = wr_valid && !wr_stall;
    assign rd = rd_valid && !rd_stall;
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= (wp_reg == PtrBits'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (rd)
                rp_reg <= (rp_reg == PtrBits'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (PtrBits+1)'(wr) - (PtrBits+1)'(rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_data;
    end
endmodule

[sv/ofd_back.sv]
`include "obj_face_index_dedup_top_defines.svh"
module ofd_back #(
    parameter int TABLE_DEPTH = ofd_pkg::TableDepth,
    parameter int INDEX_BITS = ofd_pkg::IndexBits
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  key_valid,
    output logic                  key_stall,
    input  logic [3*INDEX_BITS+2:0] key_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [INDEX_BITS-1:0] vertex_index,
    output logic                  is_new,
    output logic signed [INDEX_BITS:0] pos_index,
    output logic signed [INDEX_BITS:0] uv_index,
    output logic signed [INDEX_BITS:0] norm_index,
    output logic                  table_full
);
    localparam int AddrBits = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CntBits = $clog2(TABLE_DEPTH + 1);
    localparam int KeyBits = 3 * INDEX_BITS + 3;
    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StRead = 3'd1;
    localparam logic [2:0] StCmp = 3'd2;
    localparam logic [2:0] StOut = 3'd3;

    logic [KeyBits-1:0]  table_mem [TABLE_DEPTH];
    logic [KeyBits-1:0]  rdata_reg;
    logic [2:0]          state_reg;
    logic [CntBits-1:0]  count_reg;
    logic [CntBits-1:0]  scan_reg;
    logic [KeyBits-1:0]  key_reg;
    logic                ov_reg;
    logic [INDEX_BITS-1:0] vi_reg;
    logic                new_reg, full_reg;
    logic                do_write;
    logic                hit;
    logic                scan_end;

    assign key_stall = (state_reg != StIdle);
    assign hit = (count_reg != '0) && (rdata_reg == key_reg);
    assign scan_end = (scan_reg + 1'b1 >= count_reg);
    assign do_write = (state_reg == StCmp) && !hit && scan_end
        && (count_reg < CntBits'(TABLE_DEPTH));

    always_ff @(posedge clk)
    begin
        rdata_reg <= table_mem[scan_reg[AddrBits-1:0]];
        if (do_write)
            table_mem[count_reg[AddrBits-1:0]] <= key_reg;
        if (key_valid && !key_stall)
            key_reg <= key_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= StIdle;
            count_reg <= '0;
            scan_reg <= '0;
            ov_reg <= 1'b0;
            vi_reg <= '0;
            new_reg <= 1'b0;
            full_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == StOut && (!ov_reg || !out_stall))
                ov_reg <= 1'b1;
            else if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
            case (state_reg)
                StIdle:
                begin
                    scan_reg <= '0;
                    if (key_valid)
                        state_reg <= StRead;
                end
                StRead:
                begin
                    state_reg <= StCmp;
                end
                StCmp:
                begin
                    if (hit)
                    begin
                        vi_reg <= INDEX_BITS'(scan_reg);
                        new_reg <= 1'b0;
                        full_reg <= 1'b0;
                        state_reg <= StOut;
                    end
                    else if (scan_end)
                    begin
                        if (count_reg < CntBits'(TABLE_DEPTH))
                        begin
                            vi_reg <= INDEX_BITS'(count_reg);
                            new_reg <= 1'b1;
                            full_reg <= 1'b0;
                            count_reg <= count_reg + 1'b1;
                        end
                        else
                        begin
                            vi_reg <= '0;
                            new_reg <= 1'b0;
                            full_reg <= 1'b1;
                        end
                        state_reg <= StOut;
                    end
                    else
                    begin
                        scan_reg <= scan_reg + 1'b1;
                        state_reg <= StRead;
                    end
                end
                StOut:
                begin
                    if (!ov_reg || !out_stall)
                        state_reg <= StIdle;
                end
                default: state_reg <= StIdle;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == StOut && (!ov_reg || !out_stall))
        begin
            vertex_index <= vi_reg;
            is_new <= new_reg;
            table_full <= full_reg;
            pos_index <= key_reg[3*INDEX_BITS+2 -: INDEX_BITS+1];
            uv_index <= key_reg[2*INDEX_BITS+1 -: INDEX_BITS+1];
            norm_index <= key_reg[INDEX_BITS:0];
        end
    end

    assign out_valid = ov_reg;

    `OFD_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CntBits'(TABLE_DEPTH))
    `OFD_ASSERT_IMP(a_no_new_full, clk, rst_n, out_valid, !(is_new && table_full))
    `OFD_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
endmodule

[tb/tb_obj_face_index_dedup_top.sv]
`timescale 1ns / 100ps

module tb_obj_face_index_dedup_top;
    localparam int WatchLimit = 20000;
    localparam logic [19:0] IdxMax = 20'hfffff;

    typedef struct packed {
        logic [19:0]        vidx;
        logic               fresh;
        logic signed [20:0] pos;
        logic signed [20:0] uv;
        logic signed [20:0] norm;
        logic               full;
    } corner_t;

    typedef struct packed {
        logic [20:0] pos;
        logic [20:0] uv;
        logic [20:0] norm;
    } triple_t;

    typedef struct {
        string   text;
        bit      typed;
        corner_t want;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         text_char;
    logic               line_last;
    logic               out_valid;
    logic               out_stall;
    logic [19:0]        vertex_index;
    logic               is_new;
    logic signed [20:0] pos_index;
    logic signed [20:0] uv_index;
    logic signed [20:0] norm_index;
    logic               table_full;

    obj_face_index_dedup_top u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .text_char(text_char), .line_last(line_last),
        .out_valid(out_valid), .out_stall(out_stall),
        .vertex_index(vertex_index), .is_new(is_new),
        .pos_index(pos_index), .uv_index(uv_index), .norm_index(norm_index),
        .table_full(table_full)
    );

    // predictor state
    triple_t     dedup_keys [ofd_pkg::TableDepth];
    int          dedup_count;
    logic [19:0] acc;
    bit          pending;
    int          slashes;
    bit          skipping;
    logic [20:0] pos_r, uv_r, norm_r;

    corner_t corner_q [$];
    corner_t last_corner;
    int      errors;
    int      quiet_cycles;
    int      hold_cycles;
    bit      idle_en;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task automatic clear_line();
        acc = '0;
        pending = 0;
        slashes = 0;
        skipping = 1;
        pos_r = '0;
        uv_r = '0;
        norm_r = '0;
    endtask

    task automatic commit_number();
        logic [20:0] v;
        if (!pending)
            return;
        v = {1'b0, acc} - 21'd1;
        if (slashes == 0)
            pos_r = v;
        else if (slashes == 1)
            uv_r = v;
        else if (slashes == 2)
            norm_r = v;
        acc = '0;
        pending = 0;
    endtask

    task automatic lookup_corner();
        corner_t r;
        bit hit;
        hit = 0;
        r = '0;
        for (int i = 0; i < dedup_count; i++)
        begin
            if (dedup_keys[i] == {pos_r, uv_r, norm_r})
            begin
                hit = 1;
                r.vidx = 20'(i);
                break;
            end
        end
        if (!hit)
        begin
            if (dedup_count < ofd_pkg::TableDepth)
            begin
                dedup_keys[dedup_count] = {pos_r, uv_r, norm_r};
                r.vidx = 20'(dedup_count);
                r.fresh = 1;
                dedup_count++;
            end
            else
                r.full = 1;
        end
        r.pos = pos_r;
        r.uv = uv_r;
        r.norm = norm_r;
        corner_q.insert(corner_q.size(), r);
        last_corner = r;
        slashes = 0;
    endtask

    task automatic predict_char(logic [7:0] c, bit last);
        bit digit;
        longint nxt;
        digit = c >= ofd_pkg::CharZero && c <= ofd_pkg::CharNine;
        if (skipping && !digit)
        begin
            if (last)
                clear_line();
            return;
        end
        skipping = 0;
        if (digit)
        begin
            nxt = longint'(acc) * 10 + longint'(c - ofd_pkg::CharZero);
            acc = nxt > longint'(IdxMax) ? IdxMax : 20'(nxt);
            pending = 1;
            if (last)
                commit_number();
        end
        else
        begin
            commit_number();
            if (c == ofd_pkg::CharSlash && slashes < 3)
                slashes++;
        end
        if (c == ofd_pkg::CharSpace || last)
            lookup_corner();
        if (last)
            clear_line();
    endtask

    task automatic send_word(logic [7:0] c, bit last);
        @(negedge clk);
        while (idle_en && $urandom_range(99) < 6)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        text_char <= c;
        line_last <= last;
        do
            @(posedge clk);
        while (in_stall);
        predict_char(c, last);
    endtask

    task automatic send_line(string s);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], i == s.len() - 1);
    endtask

    task automatic send_bytes(ref logic [7:0] b [$]);
        for (int i = 0; i < b.size(); i++)
            send_word(b[i], i == b.size() - 1);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (corner_q.size() == 0);
    endtask

    function automatic string rand_number();
        case ($urandom_range(9))
            0: return "0";
            1: return $sformatf("%0d", $urandom_range(2000000));
            2: return "99999999999";
            default: return $sformatf("%0d", $urandom_range(1, 5));
        endcase
    endfunction

    task automatic build_line(ref logic [7:0] b [$]);
        string s;
        int corners;
        b.delete();
        if ($urandom_range(9) == 0)
        begin
            repeat ($urandom_range(1, 12))
                b.insert(b.size(), 8'($urandom_range(255)));
            return;
        end
        s = $urandom_range(1) ? " " : "";
        corners = $urandom_range(1, 4);
        for (int k = 0; k < corners; k++)
        begin
            s = {s, rand_number()};
            case ($urandom_range(7))
                0: s = {s, "//", rand_number()};
                1: s = {s, "/", rand_number()};
                2: s = {s, "/", rand_number(), "/", rand_number(), "/", rand_number()};
                3: s = {s, "/#", rand_number(), "/", rand_number()};
                default: s = {s, "/", rand_number(), "/", rand_number()};
            endcase
            if (k < corners - 1)
                s = {s, $urandom_range(5) == 0 ? "  " : " "};
        end
        if ($urandom_range(5) == 0)
            s = {s, " "};
        for (int i = 0; i < s.len(); i++)
            b.insert(b.size(), s[i]);
        if ($urandom_range(7) == 0)
            b[$urandom_range(b.size() - 1)] = 8'($urandom_range(255));
    endtask

    // output side: stall and compare
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles--;
        end
        else
            out_stall <= idle_en && $urandom_range(99) < 6;
    end

    always @(posedge clk)
    begin
        corner_t got, want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{vertex_index, is_new, pos_index, uv_index, norm_index, table_full};
            if (corner_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: %p", got);
            end
            else
            begin
                want = corner_q.pop_front();
                if (got != want)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected %p got %p", want, got);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchLimit)
        begin
            $display("obj_face_index_dedup_top test failed");
            $finish;
        end
    end

    initial
    begin
        row_t rows [12];
        logic [7:0] bytes [$];
        int sent;
        rst_n = 1'b0;
        in_valid = 1'b0;
        text_char = '0;
        line_last = 1'b0;
        out_stall = 1'b0;
        errors = 0;
        quiet_cycles = 0;
        hold_cycles = 0;
        idle_en = 1;
        dedup_count = 0;
        clear_line();

        rows[0] = '{"1/2/3", 1, '{20'd0, 1'b1, 21'sd0, 21'sd1, 21'sd2, 1'b0}};
        rows[1] = '{"1/2/3 1/2/3", 1, '{20'd0, 1'b0, 21'sd0, 21'sd1, 21'sd2, 1'b0}};
        rows[2] = '{"abc", 0, '0};
        rows[3] = '{"   ", 0, '0};
        rows[4] = '{"  x5  ", 0, '0};
        rows[5] = '{"0/0/0", 0, '0};
        rows[6] = '{"99999999/1048576/1048575", 0, '0};
        rows[7] = '{"1////5 2/3/4/5/6", 0, '0};
        rows[8] = '{"3/#4/5 6//7", 0, '0};
        rows[9] = '{"8/9", 0, '0};
        rows[10] = '{"2 3 4 ", 0, '0};
        rows[11] = '{"1/2/3/ ", 0, '0};

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[i])
        begin
            send_line(rows[i].text);
            if (rows[i].typed && last_corner != rows[i].want)
            begin
                errors++;
                if (errors <= 10)
                    $display("row %0d: expected %p predicted %p", i, rows[i].want,
                        last_corner);
            end
        end
        drain();

        sent = 0;
        for (int ln = 0; sent < 600; ln++)
        begin
            idle_en = !(ln >= 10 && ln < 20);
            build_line(bytes);
            if (ln == 5)
                hold_cycles = 300;
            send_bytes(bytes);
            sent += bytes.size();
            if (ln == 22)
                drain();
        end
        drain();

        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("obj_face_index_dedup_top test passed");
        else
            $display("obj_face_index_dedup_top test failed");
        $finish;
    end
endmodule
